@@ rtl/ffaa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffaa_pkg
// Shared types and constants of the first-fit arena allocator: arena and table
// sizes, status codes, request/response words and the table entry layout.
// ----------------------------------------------------------------------------
package ffaa_pkg;

   localparam int ARENA_BYTES = 4096;
   localparam int MAX_BLOCKS  = 64;

   localparam int OFF_W  = 12;                        // offset field width
   localparam int SIZE_W = 13;                        // size field width
   localparam int IDX_W  = $clog2(MAX_BLOCKS);        // table address width
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);    // holds 0..MAX_BLOCKS
   localparam int PEND_W = SIZE_W + 1;                // running end of blocks
   localparam int NEED_W = PEND_W + 1;                // end plus request size

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_GAP    = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [SIZE_W-1:0] request_size;
      logic [OFF_W-1:0]  free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] block_offset;
   } rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0]  start;
      logic [SIZE_W-1:0] length;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ rtl/ffaa_ram.sv @@
// ----------------------------------------------------------------------------
// ffaa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ffaa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/first_fit_arena_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit allocator over one arena, tracking allocated blocks in a table
// sorted by start offset, with a small sequencer walking the table RAM.
// ----------------------------------------------------------------------------
// Rejects decided at accept (bad size, full table) are answered in the cycle
//   after the accepted word; other words walk the table RAM entry by entry,
//   with a read state and a check or write state for each entry.
// Throughput: one word at a time; busy stays high until the response strobe,
//   which lasts one cycle and cannot be held off.
// Reset: synchronous; clears sequencer, block count and response strobe.
module first_fit_arena_allocator
   import ffaa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // sequencer codes
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;  // fetch next entry or test tail
   localparam logic [3:0] S_SCAN_CHK = 4'd2;  // test gap in front of entry
   localparam logic [3:0] S_INS_RD   = 4'd3;  // fetch entry to move up
   localparam logic [3:0] S_INS_WR   = 4'd4;  // write it one slot higher
   localparam logic [3:0] S_FREE_RD  = 4'd5;  // fetch entry to match
   localparam logic [3:0] S_FREE_CHK = 4'd6;  // compare start with offset
   localparam logic [3:0] S_DEL_RD   = 4'd7;  // fetch entry to move down
   localparam logic [3:0] S_DEL_WR   = 4'd8;  // write it one slot lower

   logic [3:0]        state_ff,    state_in;
   logic [CNT_W-1:0]  idx_ff,      idx_in;
   logic [CNT_W-1:0]  slot_ff,     slot_in;
   logic [CNT_W-1:0]  count_ff,    count_in;
   logic [PEND_W-1:0] prev_end_ff, prev_end_in;
   logic [SIZE_W-1:0] size_ff,     size_in;
   logic [OFF_W-1:0]  offset_ff,   offset_in;
   rsp_type           rsp_ff,      rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // table RAM ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic [ENTRY_W-1:0] rd_bits;

   // shared arithmetic on the fetched entry
   logic [NEED_W-1:0] need;      // running end plus requested size
   logic [PEND_W-1:0] entry_end; // end of fetched block
   logic [CNT_W-1:0]  idx_inc;
   logic [CNT_W-1:0]  idx_dec;

   ffaa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_data   = entry_type'(rd_bits);
   assign need      = NEED_W'(prev_end_ff) + NEED_W'(size_ff);
   assign entry_end = PEND_W'(rd_data.start) + PEND_W'(rd_data.length);
   assign idx_inc   = idx_ff + CNT_W'(1);
   assign idx_dec   = idx_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      prev_end_in  = prev_end_ff;
      size_in      = size_ff;
      offset_in    = offset_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               size_in     = req_data.request_size;
               offset_in   = req_data.free_offset;
               prev_end_in = '0;
               idx_in      = '0;
               rsp_in.block_offset = '0;
               if (req_data.kind == KIND_FREE) begin
                  state_in = S_FREE_RD;
               end else if (req_data.request_size == '0 ||
                            NEED_W'(req_data.request_size) > NEED_W'(ARENA_BYTES)) begin
                  rsp_in.status = ST_NO_GAP;
                  rsp_valid_in  = 1'b1;
               end else if (count_ff == CNT_W'(MAX_BLOCKS)) begin
                  rsp_in.status = ST_FULL;
                  rsp_valid_in  = 1'b1;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end

         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               // past the last block: try the tail of the arena
               if (need <= NEED_W'(ARENA_BYTES)) begin
                  slot_in  = count_ff;
                  idx_in   = count_ff;
                  state_in = S_INS_RD;
               end else begin
                  rsp_in.status = ST_NO_GAP;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end

         S_SCAN_CHK: begin
            if (NEED_W'(rd_data.start) >= need) begin
               // gap in front of this entry fits; open the slot here
               slot_in  = idx_ff;
               idx_in   = count_ff;
               state_in = S_INS_RD;
            end else begin
               if (entry_end > prev_end_ff) begin
                  prev_end_in = entry_end;
               end
               idx_in   = idx_inc;
               state_in = S_SCAN_RD;
            end
         end

         S_INS_RD: begin
            if (idx_ff == slot_ff) begin
               // slot is open: drop the new block in and answer
               wr_en                = 1'b1;
               wr_data.start        = prev_end_ff[OFF_W-1:0];
               wr_data.length       = size_ff;
               count_in             = count_ff + CNT_W'(1);
               rsp_in.status        = ST_OK;
               rsp_in.block_offset  = prev_end_ff[OFF_W-1:0];
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[IDX_W-1:0];
               state_in = S_INS_WR;
            end
         end

         S_INS_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_dec;
            state_in = S_INS_RD;
         end

         S_FREE_RD: begin
            if (idx_ff == count_ff) begin
               rsp_in.status = ST_NOT_FOUND;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_FREE_CHK;
            end
         end

         S_FREE_CHK: begin
            if (rd_data.start == offset_ff) begin
               state_in = S_DEL_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_FREE_RD;
            end
         end

         S_DEL_RD: begin
            if (idx_inc >= count_ff) begin
               // everything above has moved down: shrink and answer
               count_in      = count_ff - CNT_W'(1);
               rsp_in.status = ST_OK;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_inc[IDX_W-1:0];
               state_in = S_DEL_WR;
            end
         end

         S_DEL_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_inc;
            state_in = S_DEL_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      prev_end_ff <= prev_end_in;
      size_ff     <= size_in;
      offset_ff   <= offset_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/ffaa_checker.sv @@
// ----------------------------------------------------------------------------
// ffaa_checker
// Port-level checks of the allocator's command/response sequencing, bound to
// the top level.
// ----------------------------------------------------------------------------
module ffaa_checker
   import ffaa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an accepted word either starts a walk or is answered right away
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither in progress nor answered");

   // the end of a walk always delivers a response
   a_done_responds: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a response");

   // a response is never shown while a walk is still running
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // failed requests report offset zero
   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.block_offset == '0))
      else $error("nonzero offset on a failed request");

   // no response without a word accepted the cycle before or a walk ending
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset)) |-> ($past(busy) || $past(start)))
      else $error("response without a request");

endmodule

bind first_fit_arena_allocator ffaa_checker u_ffaa_checker (.*);

@@ verif/first_fit_arena_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_tb
// Self-checking bench for the first-fit arena allocator. Request words are
// driven on the start/busy handshake. A shadow copy of the block table
// predicts each response when its word is accepted. Every response strobe is
// compared field by field with the oldest prediction. Stimulus is a directed
// sweep of the corner cases, then random allocate/free traffic: mixed sizes,
// small-block churn that keeps the table full, and a final stretch without
// idle cycles.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_tb;
   import ffaa_pkg::*;

   // Slowest word is a full table walk, plus an idle burst and a wait for idle.
   // About 1850 words are sent, so the limit leaves ample margin.
   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 16;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow of the block table: entries sorted by start, count in use.
   entry_type        shadow_table [MAX_BLOCKS];
   logic [CNT_W-1:0] shadow_count = '0;

   // Predicted responses, oldest first.
   rsp_type pending_rsp [$];

   int mismatches  = 0;
   int cycle_count = 0;

   first_fit_arena_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor: apply one request word to the shadow table and return the
   // response the block must give for it.
   // ------------------------------------------------------------------------
   function automatic rsp_type serve_request(input req_type w);
      rsp_type r;
      int      need;
      int      prev_end;
      int      blk_end;
      int      slot;
      int      i;
      bit      found;
      r     = '0;
      found = 1'b0;
      slot  = 0;
      if (w.kind == KIND_ALLOC) begin
         need = int'(w.request_size);
         // Size checks come first, then the full table, then the gap scan.
         if (need == 0 || need > ARENA_BYTES) begin
            r.status = ST_NO_GAP;
         end else if (shadow_count >= MAX_BLOCKS) begin
            r.status = ST_FULL;
         end else begin
            prev_end = 0;
            slot     = int'(shadow_count);
            // Walk the gaps in address order; stop at the first that fits.
            for (i = 0; i < int'(shadow_count); i++) begin
               if (!found) begin
                  blk_end = int'(shadow_table[i].start) + int'(shadow_table[i].length);
                  if (int'(shadow_table[i].start) >= prev_end &&
                      int'(shadow_table[i].start) - prev_end >= need) begin
                     slot  = i;
                     found = 1'b1;
                  end else if (blk_end > prev_end) begin
                     prev_end = blk_end;
                  end
               end
            end
            // Otherwise try the tail of the arena.
            if (!found && ARENA_BYTES - prev_end < need) begin
               r.status = ST_NO_GAP;
            end else begin
               // Open a hole at the slot, keeping the table sorted.
               for (i = int'(shadow_count); i > slot; i--)
                  shadow_table[i] = shadow_table[i-1];
               shadow_table[slot].start  = prev_end[OFF_W-1:0];
               shadow_table[slot].length = need[SIZE_W-1:0];
               shadow_count              = shadow_count + 1'b1;
               r.status                  = ST_OK;
               r.block_offset            = prev_end[OFF_W-1:0];
            end
         end
      end else begin
         // Drop the lowest-index entry whose start matches.
         for (i = 0; i < int'(shadow_count); i++) begin
            if (!found && shadow_table[i].start == w.free_offset) begin
               slot  = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            r.status = ST_NOT_FOUND;
         end else begin
            for (i = slot; i + 1 < int'(shadow_count); i++)
               shadow_table[i] = shadow_table[i+1];
            shadow_count = shadow_count - 1'b1;
            r.status     = ST_OK;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Response checker: every strobe must match the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: status %0d, block_offset %0d",
                   rsp_data.status, rsp_data.block_offset);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.block_offset !== want.block_offset) begin
               $error("block_offset: expected %0d, actual %0d",
                      want.block_offset, rsp_data.block_offset);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Word builders. Fill the ignored field with random bits so the block
   // is seen to ignore it.
   // ------------------------------------------------------------------------
   function automatic req_type alloc_word(input int size);
      req_type w;
      w.kind         = KIND_ALLOC;
      w.request_size = size[SIZE_W-1:0];
      w.free_offset  = OFF_W'($urandom_range(2**OFF_W - 1));
      return w;
   endfunction

   function automatic req_type free_word(input int offset);
      req_type w;
      w.kind         = KIND_FREE;
      w.request_size = SIZE_W'($urandom_range(2**SIZE_W - 1));
      w.free_offset  = offset[OFF_W-1:0];
      return w;
   endfunction

   // Random word. Most frees target a live block so the table sees real
   // churn; the rest probe unknown offsets. Allocate sizes are mostly small,
   // with some zero, oversize and large requests mixed in.
   function automatic req_type random_word(input int alloc_pct, input int size_cap,
                                           input int large_pct);
      int pick;
      if ($urandom_range(99) < alloc_pct) begin
         pick = $urandom_range(99);
         if (pick < 4)
            return alloc_word(0);
         else if (pick < 8)
            return alloc_word($urandom_range(2**SIZE_W - 1, ARENA_BYTES + 1));
         else if (pick < 8 + large_pct)
            return alloc_word($urandom_range(ARENA_BYTES, ARENA_BYTES / 4));
         else
            return alloc_word($urandom_range(size_cap, 1));
      end
      if (shadow_count != 0 && $urandom_range(99) < 75)
         return free_word(int'(shadow_table[$urandom_range(shadow_count - 1)].start));
      return free_word($urandom_range(2**OFF_W - 1));
   endfunction

   // ------------------------------------------------------------------------
   // Drive one word and hold it until the block takes it. Call at a rising
   // edge; return at the accepting edge with start still high.
   // ------------------------------------------------------------------------
   task automatic send_word(input req_type w);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp.push_back(serve_request(w));
   endtask

   // Random idle burst after an accepted word. Drop start at once so the
   // old word is never taken twice. Let the gap fall either inside the
   // block's work or after it has gone idle.
   task automatic idle_burst(input bit enable);
      if (enable && $urandom_range(99) < 30) begin
         start <= 1'b0;
         if ($urandom_range(1))
            do @(posedge clock); while (busy !== 1'b0);
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Corner cases from an empty table: bad sizes, whole-arena block, unknown
   // offsets, front hole reuse, exact fits in a middle gap and at the tail.
   task automatic test_directed_cases();
      req_type seq [$];
      seq = {free_word(0),                  // free on an empty table
             alloc_word(0),                 // zero size
             alloc_word(ARENA_BYTES + 1),   // just over the arena
             alloc_word(2**SIZE_W - 1),     // widest size value
             alloc_word(ARENA_BYTES),       // whole arena
             alloc_word(1),                 // no room anywhere
             free_word(2**OFF_W - 1),       // unknown offset, all ones
             free_word(0),
             alloc_word(100),
             alloc_word(200),
             alloc_word(300),
             free_word(0),                  // open a hole at the front
             alloc_word(101),               // too big for it: goes to tail
             alloc_word(100),               // reuse the front hole
             free_word(100),
             alloc_word(200),               // exact fit between blocks
             free_word(600),
             alloc_word(ARENA_BYTES - 600), // exact fit at the tail
             alloc_word(1),
             free_word(50),                 // inside a block, not a start
             free_word(0),
             free_word(100),
             free_word(300),
             free_word(600)};
      foreach (seq[k]) begin
         send_word(seq[k]);
         idle_burst(1'b1);
      end
   endtask

   // Mixed sizes over the whole arena: fragmentation and no-gap rejects.
   task automatic test_mixed_traffic(input int words);
      repeat (words) begin
         send_word(random_word(55, 512, 6));
         idle_burst(1'b1);
      end
   endtask

   // Small blocks with allocate-heavy traffic: fill the table and keep it
   // churning around the full mark.
   task automatic test_table_churn(input int words);
      repeat (words) begin
         send_word(random_word(75, 32, 1));
         idle_burst(1'b1);
      end
   endtask

   // Back-to-back words with no idle cycles on the request side.
   task automatic test_back_to_back(input int words);
      repeat (words) begin
         send_word(random_word(55, 256, 4));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_mixed_traffic(750);
      test_table_churn(550);
      test_back_to_back(525);

      // Release the handshake, drain the predictions, then watch for stray
      // strobes a little longer.
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
